FILE: rtl/sacr_pkg.sv
// package: shared constants, types and helpers for the cache replacement block
package sacr_pkg;

  localparam int unsigned SetsDefault = 64;
  localparam int unsigned WaysDefault = 4;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned TagW    = 64;
  localparam int unsigned StampW  = 64;
  localparam int unsigned CountW  = 32;
  localparam int unsigned TotalW  = 64;
  localparam int unsigned SetOutW = 6;
  localparam int unsigned WayOutW = 2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] RegPolicy = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIndex  = 2'd2;

  localparam logic [1:0] PolLru  = 2'd0;
  localparam logic [1:0] PolFifo = 2'd1;
  localparam logic [1:0] PolLfu  = 2'd2;

  // output word: hit, evicted, set_index, way, evicted_tag, then three totals
  localparam int unsigned OutBits = 1 + 1 + SetOutW + WayOutW + TagW + 3 * TotalW;
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;

  typedef struct packed {
    logic [1:0] policy;
    logic [3:0] line_shift;
    logic [2:0] set_bits;
  } cfg_t;

  // one line as stored in the line memory
  typedef struct packed {
    logic              valid;
    logic [TagW-1:0]   tag;
    logic [StampW-1:0] stamp;
    logic [CountW-1:0] count;
  } line_t;

endpackage

FILE: rtl/sacr_cfg.sv
// configuration register file
module sacr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sacr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sacr_pkg::CfgDataW-1:0] cfg_data_i,
  output sacr_pkg::cfg_t                cfg_o
);

  sacr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sacr_pkg::RegPolicy: cfg_d.policy     = cfg_data_i[1:0];
        sacr_pkg::RegOffset: cfg_d.line_shift = cfg_data_i;
        sacr_pkg::RegIndex:  cfg_d.set_bits   = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{policy: sacr_pkg::PolLru, line_shift: 4'd6, set_bits: 3'd6};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/sacr_line_mem.sv
// line memory: tag, stamp and use count per line, plus per-line valid bits
module sacr_line_mem #(
  parameter int unsigned Lines = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(Lines)-1:0] rd_addr_i,
  output sacr_pkg::line_t          rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Lines)-1:0] wr_addr_i,
  input  sacr_pkg::line_t          wr_data_i
);

  logic [sacr_pkg::TagW-1:0]   tag_mem   [Lines];
  logic [sacr_pkg::StampW-1:0] stamp_mem [Lines];
  logic [sacr_pkg::CountW-1:0] count_mem [Lines];
  logic [Lines-1:0]            valid_q;
  logic                        rd_valid_q;
  logic [sacr_pkg::TagW-1:0]   rd_tag_q;
  logic [sacr_pkg::StampW-1:0] rd_stamp_q;
  logic [sacr_pkg::CountW-1:0] rd_count_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_addr_i]   <= wr_data_i.tag;
      stamp_mem[wr_addr_i] <= wr_data_i.stamp;
      count_mem[wr_addr_i] <= wr_data_i.count;
    end
    rd_tag_q   <= tag_mem[rd_addr_i];
    rd_stamp_q <= stamp_mem[rd_addr_i];
    rd_count_q <= count_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= wr_data_i.valid;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // entries never written read as zero stamp and count via valid
  always_comb begin
    rd_data_o.valid = rd_valid_q;
    rd_data_o.tag   = rd_tag_q;
    rd_data_o.stamp = rd_valid_q ? rd_stamp_q : '0;
    rd_data_o.count = rd_valid_q ? rd_count_q : '0;
  end

endmodule

FILE: rtl/sacr_ctrl.sv
// access sequencer: scans the ways of a set, picks a victim, writes back
module sacr_ctrl #(
  parameter int unsigned Sets = sacr_pkg::SetsDefault,
  parameter int unsigned Ways = sacr_pkg::WaysDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sacr_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sacr_pkg::AddrW-1:0]      address_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sacr_pkg::OutW-1:0]       out_data_o,
  output logic [$clog2(Sets*Ways)-1:0]    rd_addr_o,
  input  sacr_pkg::line_t                 rd_data_i,
  output logic                            wr_en_o,
  output logic [$clog2(Sets*Ways)-1:0]    wr_addr_o,
  output sacr_pkg::line_t                 wr_data_o
);

  localparam int unsigned Lines = Sets * Ways;
  localparam int unsigned LAW   = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int unsigned SetW  = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned WayW  = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned CntW  = $clog2(Ways + 1);
  localparam int unsigned SetLg = $clog2(Sets + 1) - 1;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StWrite = 4'b0100,
    StOut   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic [CntW-1:0] ck_cnt_q, ck_cnt_d;
  logic [SetW-1:0] set_q, set_d;
  logic [sacr_pkg::TagW-1:0] tag_q, tag_d;
  logic hit_q, hit_d, inv_q, inv_d;
  logic [WayW-1:0] hway_q, hway_d, iway_q, iway_d, vway_q, vway_d;
  sacr_pkg::line_t hline_q, hline_d, vline_q, vline_d;
  logic [sacr_pkg::StampW-1:0] clk_q, clk_d;
  logic [sacr_pkg::TotalW-1:0] hits_q, hits_d, miss_q, miss_d, evs_q, evs_d;
  logic [sacr_pkg::OutW-1:0] out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [2:0] ib;
  logic [sacr_pkg::AddrW-1:0] shifted, set_mask;
  logic [4:0] tag_sh;
  logic cur_way_valid;
  logic [WayW-1:0] ck_way;
  logic better;
  sacr_pkg::line_t wline;
  logic [WayW-1:0] fway;
  logic ev;
  logic adv;

  assign ib = (32'(cfg_i.set_bits) > SetLg) ? 3'(SetLg) : cfg_i.set_bits;
  assign shifted  = address_i >> cfg_i.line_shift;
  assign set_mask = (64'd1 << ib) - 64'd1;
  assign tag_sh   = 5'(cfg_i.line_shift) + 5'(ib);
  assign ck_way   = WayW'(ck_cnt_q);
  assign cur_way_valid = rd_data_i.valid;

  // victim compare against current candidate
  always_comb begin
    better = 1'b0;
    if (cfg_i.policy == sacr_pkg::PolLru || cfg_i.policy == sacr_pkg::PolFifo) begin
      better = rd_data_i.stamp < vline_q.stamp;
    end else if (cfg_i.policy == sacr_pkg::PolLfu) begin
      better = (rd_data_i.count < vline_q.count) ||
               (rd_data_i.count == vline_q.count && rd_data_i.stamp < vline_q.stamp);
    end
  end

  assign ev   = !hit_q && !inv_q;
  assign fway = hit_q ? hway_q : (inv_q ? iway_q : vway_q);
  assign adv  = (cfg_i.policy == sacr_pkg::PolLru) || (cfg_i.policy == sacr_pkg::PolLfu) ||
                (cfg_i.policy == sacr_pkg::PolFifo && !hit_q);

  always_comb begin
    wline = hit_q ? hline_q : vline_q;
    if (!hit_q) begin
      wline.valid = 1'b1;
      wline.tag   = tag_q;
      wline.count = '0;
    end
    if (adv) begin
      wline.stamp = clk_q + 64'd1;
    end
    if (cfg_i.policy == sacr_pkg::PolLfu) begin
      if (!hit_q) begin
        wline.count = 32'd1;
      end else if (wline.count != '1) begin
        wline.count = wline.count + 32'd1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    rd_cnt_d = rd_cnt_q;
    ck_cnt_d = ck_cnt_q;
    set_d = set_q;
    tag_d = tag_q;
    hit_d = hit_q;
    inv_d = inv_q;
    hway_d = hway_q;
    iway_d = iway_q;
    vway_d = vway_q;
    hline_d = hline_q;
    vline_d = vline_q;
    clk_d = clk_q;
    hits_d = hits_q;
    miss_d = miss_q;
    evs_d = evs_q;
    out_d = out_q;
    out_valid_d = out_valid_q;
    wr_en_o = 1'b0;
    in_ready_o = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          set_d = SetW'(shifted & set_mask);
          tag_d = address_i >> tag_sh;
          hit_d = 1'b0;
          inv_d = 1'b0;
          rd_cnt_d = CntW'(1);
          ck_cnt_d = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (rd_cnt_q != CntW'(Ways)) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end
        if (!hit_q && cur_way_valid && rd_data_i.tag == tag_q) begin
          hit_d = 1'b1;
          hway_d = ck_way;
          hline_d = rd_data_i;
        end
        if (!inv_q && !cur_way_valid) begin
          inv_d = 1'b1;
          iway_d = ck_way;
          vline_d = rd_data_i;
        end else if (!inv_q && (ck_cnt_q == '0 || better)) begin
          vway_d = ck_way;
          vline_d = rd_data_i;
        end
        ck_cnt_d = ck_cnt_q + CntW'(1);
        if (ck_cnt_q == CntW'(Ways - 1)) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        if (!out_valid_q || out_ready_i) begin
          wr_en_o = 1'b1;
          if (adv) begin
            clk_d = clk_q + 64'd1;
          end
          if (hit_q) begin
            hits_d = hits_q + 64'd1;
          end else begin
            miss_d = miss_q + 64'd1;
          end
          if (ev) begin
            evs_d = evs_q + 64'd1;
          end
          out_d = '0;
          out_d[sacr_pkg::OutBits-1:0] = {
            (ev ? evs_q + 64'd1 : evs_q),
            (hit_q ? miss_q : miss_q + 64'd1),
            (hit_q ? hits_q + 64'd1 : hits_q),
            (ev ? vline_q.tag : 64'd0),
            2'(32'(fway)),
            6'(32'(set_q)),
            ev, hit_q};
          out_valid_d = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // way 0 is read in the accepting cycle, so the address follows the incoming set
  assign rd_addr_o = LAW'(32'(set_d) * Ways + 32'(rd_cnt_q == CntW'(Ways) ? '0 : rd_cnt_q));
  assign wr_addr_o = LAW'(32'(set_q) * Ways + 32'(fway));
  assign wr_data_o = wline;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rd_cnt_q <= '0;
      ck_cnt_q <= '0;
      hit_q <= 1'b0;
      inv_q <= 1'b0;
      clk_q <= '0;
      hits_q <= '0;
      miss_q <= '0;
      evs_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_cnt_q <= rd_cnt_d;
      ck_cnt_q <= ck_cnt_d;
      hit_q <= hit_d;
      inv_q <= inv_d;
      clk_q <= clk_d;
      hits_q <= hits_d;
      miss_q <= miss_d;
      evs_q <= evs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q <= set_d;
    tag_q <= tag_d;
    hway_q <= hway_d;
    iway_q <= iway_d;
    vway_q <= vway_d;
    hline_q <= hline_d;
    vline_q <= vline_d;
    out_q <= out_d;
  end

  // new result appears only from the write-back step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StWrite)
    else $error("result without write-back");
  // a hit and an eviction never go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q[0] && out_q[1]))
    else $error("hit flagged with eviction");
  // the memory is written once per access, in the write-back step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |=> state_q == StOut)
    else $error("stray memory write");
  // totals grow by one per access; hit and miss totals move only in write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StWrite |=> $stable(hits_q) && $stable(miss_q))
    else $error("totals moved outside write-back");

endmodule

FILE: rtl/set_assoc_cache_replacement.sv
// top level: set-associative cache tag lookup with LRU, FIFO and LFU replacement
//
// one word on s_axis carries a 64-bit byte address; one word on m_axis
// returns hit, evicted flag, set, way, evicted tag and running totals.
// config registers (policy, line offset width, set index width) are written
// through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while
// no access is in flight, and the block itself does not enforce this. the
// ways of the set are read one per cycle from the line memory, whose read
// port is registered, then a write-back step updates the chosen line and
// the result register. one access is worked on at a time, so a new word is
// taken only once the previous access has passed its write-back step.
// the result register holds while m_axis_tready is low; the next access
// may be accepted and scanned meanwhile, but its write-back waits until
// the held result is taken.
// reset clears all valid bits at once, the stamp clock, the totals and
// the configuration (LRU, offset 6, index 6); no clearing pass is needed.
module set_assoc_cache_replacement #(
  parameter int unsigned Sets = sacr_pkg::SetsDefault,
  parameter int unsigned Ways = sacr_pkg::WaysDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sacr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sacr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // address
  input  logic [sacr_pkg::AddrW-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit, evicted, set_index, way, evicted_tag, hit_total, miss_total, eviction_total
  output logic [sacr_pkg::OutW-1:0]     m_axis_tdata
);

  localparam int unsigned Lines = Sets * Ways;
  localparam int unsigned LAW   = (Lines > 1) ? $clog2(Lines) : 1;

  sacr_pkg::cfg_t  cfg;
  sacr_pkg::line_t rd_data, wr_data;
  logic [LAW-1:0]  rd_addr, wr_addr;
  logic            wr_en;

  sacr_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  sacr_line_mem #(.Lines(1 << LAW)) u_mem (
    .clk_i, .rst_ni,
    .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  sacr_ctrl #(.Sets(Sets), .Ways(Ways)) u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .address_i(s_axis_tdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata),
    .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data)
  );

endmodule
